// File: rtl/core/pps_pkg.sv
// shared types and constants of the preemptive priority scheduler
package pps_pkg;

  localparam int SLOTS         = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int BURST_BITS    = 16;
  localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  task_id;
    logic [31:0] arrive_at;
    logic [7:0]  priority_req;
    logic [15:0] burst;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        ran_valid;
    logic [7:0]  ran_task;
    logic        completed;
    logic [31:0] completion_time;
    logic        all_done;
  } out_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [7:0]               task_id;
    logic [31:0]              arrival;
    logic [PRIORITY_BITS-1:0] prio;
    logic [BURST_BITS-1:0]    remaining;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/pps_ram.sv
// generic single-port-write ram with registered read
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/preemptive_priority_scheduler.sv
// top level of the preemptive priority scheduler
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  req     | in        | req_valid/req_ready  | in_t: operation, task, arrival, prio, burst
//  rsp     | out       | rsp_valid/rsp_ready  | out_t: accepted, ran, completed, time, done
//
// an arrive item is stored when it is accepted, then handed over before the next accept
// a tick item scans the table with one slot memory read per cycle,
// then passes through a write-back state and a hand-over state
// reset clears the slot valid bits, the time counter and the handshake state;
// the slot memory itself is not cleared, an entry is only used while its valid bit is set
// a stalled rsp holds the finished item; the next req is taken meanwhile and its result
// waits in the hand-over state until the output register frees
module preemptive_priority_scheduler import pps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  in_t  req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output out_t rsp
);

  state_t state;
  state_t state_next;

  // table bookkeeping
  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] slot_valid_next;
  logic [31:0]      cur_time;

  // scan pointer: index of the slot whose read data is on the memory output
  logic [SLOT_W-1:0] cmp_idx;
  logic              scan_last;

  // best candidate found so far in the scan
  logic              best_found;
  logic [SLOT_W-1:0] best_idx;
  slot_t             best;
  logic              best_done;

  // result waiting to be handed to the output register
  out_t res;
  logic out_load;

  // slot memory port
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  slot_t             ram_rdata;

  // lowest free slot for an arrive
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic req_take;
  logic is_arrive;
  logic eligible;
  logic better;

  pps_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_take  = req_valid && req_ready;
  assign is_arrive = (req.operation == OP_ARRIVE);
  assign scan_last = (cmp_idx == SLOT_W'(SLOTS - 1));
  assign best_done = (best.remaining <= BURST_BITS'(1));
  assign out_load  = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  // priority encoder over the valid bits, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // candidate on the memory output: arrived by now and strictly higher priority,
  // so ties stay with the lower slot index
  assign eligible = slot_valid[cmp_idx] && (ram_rdata.arrival <= cur_time);
  assign better   = eligible && (!best_found || (ram_rdata.prio > best.prio));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = is_arrive ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs and memory port
  always_comb begin
    req_ready       = (state == ST_IDLE);
    ram_we          = 1'b0;
    ram_waddr       = best_idx;
    ram_wdata       = best;
    ram_raddr       = '0;
    slot_valid_next = slot_valid;
    case (state)
      ST_IDLE: begin
        // slot 0 is read here so the scan starts with data in hand
        if (req_take && is_arrive && free_found) begin
          ram_we                    = 1'b1;
          ram_waddr                 = free_idx;
          ram_wdata.task_id         = req.task_id;
          ram_wdata.arrival         = req.arrive_at;
          ram_wdata.prio            = PRIORITY_BITS'(req.priority_req);
          ram_wdata.remaining       = BURST_BITS'(req.burst);
          slot_valid_next[free_idx] = 1'b1;
        end
      end
      ST_SCAN: begin
        ram_raddr = SLOT_W'(cmp_idx + 1'b1);
      end
      ST_WRITE: begin
        if (best_found) begin
          if (best_done) begin
            slot_valid_next[best_idx] = 1'b0;
          end else begin
            ram_we              = 1'b1;
            ram_wdata.remaining = best.remaining - BURST_BITS'(1);
          end
        end
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      cur_time   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      slot_valid <= slot_valid_next;
      if (state == ST_WRITE) begin
        cur_time <= cur_time + 32'd1;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // scan and result datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_take) begin
      cmp_idx    <= '0;
      best_found <= 1'b0;
      if (is_arrive) begin
        res.accepted        <= free_found;
        res.ran_valid       <= 1'b0;
        res.ran_task        <= '0;
        res.completed       <= 1'b0;
        res.completion_time <= cur_time;
        res.all_done        <= (slot_valid_next == '0);
      end
    end
    if (state == ST_SCAN) begin
      cmp_idx <= SLOT_W'(cmp_idx + 1'b1);
      if (better) begin
        best_found <= 1'b1;
        best_idx   <= cmp_idx;
        best       <= ram_rdata;
      end
    end
    if (state == ST_WRITE) begin
      res.accepted        <= 1'b0;
      res.ran_valid       <= best_found;
      res.ran_task        <= best_found ? best.task_id : 8'd0;
      res.completed       <= best_found && best_done;
      res.completion_time <= cur_time + 32'd1;
      res.all_done        <= (slot_valid_next == '0);
    end
    if (out_load) begin
      rsp <= res;
    end
  end

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the preemptive priority scheduler
module testbench;
  import pps_pkg::*;

  localparam int WATCHDOG_LIMIT     = 3000;
  localparam int OUTPUT_HOLD_CYCLES = 300;
  localparam int RANDOM_TARGET      = 1700;
  localparam int DRAIN_GUARD        = 400;
  localparam int MAX_PRINTED        = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  always #1 clk = ~clk;

  preemptive_priority_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // scheduler state as the testbench sees it
  bit                       sched_live    [SLOTS];
  logic [7:0]               sched_id      [SLOTS];
  logic [31:0]              sched_arrival [SLOTS];
  logic [PRIORITY_BITS-1:0] sched_prio    [SLOTS];
  logic [BURST_BITS-1:0]    sched_left    [SLOTS];
  logic [31:0]              sched_clock = '0;

  out_t expected_q[$];
  int   mismatch_count = 0;
  int   items_sent = 0;
  int   stall_cycles = 0;
  bit   idle_on = 1'b1;
  bit   hold_output = 1'b0;

  function automatic int stored_tasks();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += sched_live[i];
    return n;
  endfunction

  // advance the scheduler state by one item and return the result it should give
  function automatic out_t predict_schedule(in_t item);
    out_t res;
    int   best;
    res = '0;
    if (item.operation == OP_ARRIVE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!sched_live[i]) begin
          sched_live[i]    = 1'b1;
          sched_id[i]      = item.task_id;
          sched_arrival[i] = item.arrive_at;
          sched_prio[i]    = item.priority_req[PRIORITY_BITS-1:0];
          sched_left[i]    = item.burst[BURST_BITS-1:0];
          res.accepted     = 1'b1;
          break;
        end
      end
    end else begin
      // strict greater-than keeps the lowest slot on a tie
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (sched_live[i] && sched_arrival[i] <= sched_clock) begin
          if (best < 0 || sched_prio[i] > sched_prio[best]) best = i;
        end
      end
      sched_clock = sched_clock + 32'd1;
      if (best >= 0) begin
        res.ran_valid = 1'b1;
        res.ran_task  = sched_id[best];
        // a zero burst finishes on its first run, like a burst of one
        if (sched_left[best] <= 1) begin
          sched_left[best] = '0;
          sched_live[best] = 1'b0;
          res.completed    = 1'b1;
        end else begin
          sched_left[best] = sched_left[best] - 1'b1;
        end
      end
    end
    res.completion_time = sched_clock;
    res.all_done        = (stored_tasks() == 0);
    return res;
  endfunction

  function automatic in_t arrive_item(logic [7:0] id, logic [31:0] arr, logic [7:0] prio,
                                      logic [15:0] burst);
    in_t item;
    item.operation    = OP_ARRIVE;
    item.task_id      = id;
    item.arrive_at    = arr;
    item.priority_req = prio;
    item.burst        = burst;
    return item;
  endfunction

  // the other fields are don't-care on a tick, so fill them with noise
  function automatic in_t tick_item();
    in_t item;
    item.operation    = OP_TICK;
    item.task_id      = 8'($urandom_range(0, 255));
    item.arrive_at    = $urandom;
    item.priority_req = 8'($urandom_range(0, 255));
    item.burst        = 16'($urandom_range(0, 65535));
    return item;
  endfunction

  // arrival in the past or up to 12 ticks ahead, mostly small priorities and ids so ties and repeats show up
  function automatic in_t random_arrive(int max_burst);
    logic [31:0] arr;
    logic [7:0]  id;
    logic [7:0]  prio;
    if ($urandom_range(0, 1) == 0) arr = $urandom_range(0, sched_clock);
    else arr = sched_clock + $urandom_range(0, 12);
    id   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    return arrive_item(id, arr, prio, 16'($urandom_range(0, max_burst)));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // offer one item, hold it until taken, then record what it should produce
  task automatic send_item(in_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_q.insert(expected_q.size(), predict_schedule(item));
    items_sent++;
  endtask

  task automatic drain_table();
    int guard;
    guard = 0;
    while (stored_tasks() != 0 && guard < DRAIN_GUARD) begin
      send_item(tick_item());
      guard++;
    end
    repeat ($urandom_range(0, 2)) send_item(tick_item());
  endtask

  // empty table: the tick runs nothing but time still moves
  task automatic test_idle_tick();
    idle_on = 1'b1;
    send_item(tick_item());
  endtask

  // fill every slot with extremes, a zero burst, a repeated id, a late arrival, then overflow
  task automatic test_table_fill();
    send_item(arrive_item(8'hFF, 32'd0, 8'h00, 16'd1));
    send_item(arrive_item(8'h00, 32'd0, 8'hFF, 16'd2));
    send_item(arrive_item(8'h07, 32'd0, 8'h80, 16'd0));
    send_item(arrive_item(8'h07, 32'd0, 8'h80, 16'd1));
    send_item(arrive_item(8'hAA, 32'd3, 8'hFF, 16'd1));
    for (int i = 5; i < SLOTS; i++)
      send_item(arrive_item(8'(8'hA0 + i), 32'd0, 8'($urandom_range(1, 127)),
                            16'($urandom_range(1, 3))));
    send_item(arrive_item(8'h33, 32'd0, 8'hFF, 16'hFFFF));
  endtask

  // highest priority first, late arrival preempts, equal priorities by slot order
  task automatic test_pick_order();
    repeat (6) send_item(tick_item());
  endtask

  // the receiver stops for a long stretch while items keep coming
  task automatic test_output_backpressure();
    idle_on     = 1'b0;
    hold_output = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item((i % 3 == 0) ? tick_item() : random_arrive(4));
  endtask

  task automatic test_random_mix();
    int pick;
    while (items_sent < RANDOM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise: any operation, longer bursts
        repeat ($urandom_range(1, 6))
          send_item(($urandom_range(0, 1) == 0) ? tick_item() : random_arrive(15));
      end else if (pick < 20) begin
        while (stored_tasks() < SLOTS) send_item(random_arrive(6));
        repeat ($urandom_range(1, 3)) send_item(random_arrive(6));
      end else if (pick < 40) begin
        drain_table();
      end else begin
        repeat ($urandom_range(1, 4)) send_item(random_arrive(6));
        repeat ($urandom_range(1, 8)) send_item(tick_item());
      end
    end
  endtask

  // long bursts and far-future arrivals park in the table, so they come last
  task automatic test_parked_extremes();
    idle_on = 1'b1;
    drain_table();
    send_item(arrive_item(8'($urandom_range(0, 255)), 32'd0, 8'hFF, 16'hFFFF));
    repeat (3) send_item(tick_item());
    while (stored_tasks() < SLOTS)
      send_item(arrive_item(8'($urandom_range(0, 255)), $urandom | 32'h8000_0000,
                            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))));
    send_item(arrive_item(8'h5A, 32'd0, 8'hFF, 16'hFFFF));
    repeat (2) send_item(tick_item());
  endtask

  // receiver: random stall per result, plus one long hold on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        rsp_ready <= 1'b0;
        repeat (OUTPUT_HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid && !hold_output);
    end
  end

  // compare each taken result against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected, time", rsp.completion_time, '0);
      end else begin
        want = expected_q.pop_front();
        if (rsp.accepted !== want.accepted)
          report_mismatch("accepted", 32'(rsp.accepted), 32'(want.accepted));
        if (rsp.ran_valid !== want.ran_valid)
          report_mismatch("ran_valid", 32'(rsp.ran_valid), 32'(want.ran_valid));
        if (rsp.ran_task !== want.ran_task)
          report_mismatch("ran_task", 32'(rsp.ran_task), 32'(want.ran_task));
        if (rsp.completed !== want.completed)
          report_mismatch("completed", 32'(rsp.completed), 32'(want.completed));
        if (rsp.completion_time !== want.completion_time)
          report_mismatch("completion_time", rsp.completion_time, want.completion_time);
        if (rsp.all_done !== want.all_done)
          report_mismatch("all_done", 32'(rsp.all_done), 32'(want.all_done));
      end
    end
  end

  // a run that stops moving items for too long is a failure
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_tick();
    test_table_fill();
    test_pick_order();
    test_output_backpressure();
    test_random_mix();
    test_parked_extremes();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * (SLOTS + 3)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
